[rtl/core/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg
// Types and constants for the JSON string unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  // Decoder modes
  localparam logic [2:0] ModePlain = 3'd0;
  localparam logic [2:0] ModeEsc   = 3'd1;
  localparam logic [2:0] ModeHex0  = 3'd2;
  localparam logic [2:0] ModeHex3  = 3'd5;

  // Characters of interest
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChB         = 8'h62;
  localparam logic [7:0] ChF         = 8'h66;
  localparam logic [7:0] ChN         = 8'h6E;
  localparam logic [7:0] ChR         = 8'h72;
  localparam logic [7:0] ChT         = 8'h74;
  localparam logic [7:0] ChU         = 8'h75;

  // Control codes produced by single-letter escapes
  localparam logic [7:0] CodeBs = 8'h08;
  localparam logic [7:0] CodeFf = 8'h0C;
  localparam logic [7:0] CodeLf = 8'h0A;
  localparam logic [7:0] CodeCr = 8'h0D;
  localparam logic [7:0] CodeHt = 8'h09;

  // UTF-8 framing
  localparam logic [7:0] Utf8Lead2 = 8'hC0;
  localparam logic [7:0] Utf8Lead3 = 8'hE0;
  localparam logic [7:0] Utf8Cont  = 8'h80;

  // Result buffer
  localparam int unsigned BufDepth = 8;
  localparam int unsigned BufPtrW  = 3;
  localparam int unsigned BufCntW  = 4;
  localparam int unsigned MaxRes   = 3;

  // One result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       string_done;
    logic       decode_error;
    logic       last;
  } res_t;

  // Hex digit value; bit 4 set when the character is not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      v = {1'b0, c[3:0] + 4'd9};
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/core/json_string_unescape_utf8.sv]
// Path: an accepted input word is held in the input register, then decoded
//   into the result buffer, whose head word drives the outputs.
// Throughput: one input word per cycle while the 8-entry result buffer holds
//   five or fewer words; output drains one word per cycle while out_ready_i is
//   high, and a three-byte UTF-8 expansion yields three output words.
// Reset: rst_ni clears the decoder mode, code accumulator and buffer pointers.
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Unescapes a JSON string body byte stream and encodes \u units as UTF-8.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8
  import jsu_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire  [7:0] in_byte_i,
  input  wire        end_of_input_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output logic       string_done_o,
  output logic       decode_error_o,
  output logic       last_o
);

  // Input register
  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_eoi_q;

  // Decoder state
  logic [2:0]  mode_q, mode_d;
  logic [15:0] code_q, code_d;

  // Result buffer
  res_t               buf_q [BufDepth];
  logic [BufPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [BufCntW-1:0] cnt_q;

  logic        s1_fire, in_fire, out_fire, room;
  logic [1:0]  n_res;
  res_t        res [MaxRes];
  logic [4:0]  hv;
  logic [15:0] cp;

  assign room       = cnt_q <= BufCntW'(BufDepth - MaxRes);
  assign s1_fire    = s1_valid_q && room;
  assign in_ready_o = !s1_valid_q || room;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_valid_o = cnt_q != '0;
  assign out_fire   = out_valid_o && out_ready_i;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= in_byte_i;
      s1_eoi_q  <= end_of_input_i;
    end
  end

  // Decode one byte into up to three result words
  assign hv = hex_val(s1_byte_q);
  assign cp = {code_q[11:0], hv[3:0]};

  always_comb begin
    mode_d = mode_q;
    code_d = code_q;
    n_res  = 2'd0;
    for (int k = 0; k < MaxRes; k++) res[k] = '0;

    if (mode_q == ModeEsc) begin
      if (s1_eoi_q) begin
        res[0].string_done  = 1'b1;
        res[0].decode_error = 1'b1;
        n_res  = 2'd1;
        mode_d = ModePlain;
        code_d = '0;
      end else begin
        mode_d = ModePlain;
        n_res  = 2'd1;
        res[0].has_byte = 1'b1;
        unique case (s1_byte_q)
          ChQuote, ChBackslash, ChSlash: res[0].out_byte = s1_byte_q;
          ChB: res[0].out_byte = CodeBs;
          ChF: res[0].out_byte = CodeFf;
          ChN: res[0].out_byte = CodeLf;
          ChR: res[0].out_byte = CodeCr;
          ChT: res[0].out_byte = CodeHt;
          ChU: begin
            n_res           = 2'd0;
            res[0].has_byte = 1'b0;
            mode_d          = ModeHex0;
            code_d          = '0;
          end
          default: begin
            res[0].has_byte     = 1'b0;
            res[0].string_done  = 1'b1;
            res[0].decode_error = 1'b1;
            code_d              = '0;
          end
        endcase
      end
    end else if (mode_q >= ModeHex0 && mode_q <= ModeHex3) begin
      if (s1_eoi_q || hv[4]) begin
        res[0].string_done  = 1'b1;
        res[0].decode_error = 1'b1;
        n_res  = 2'd1;
        mode_d = ModePlain;
        code_d = '0;
      end else if (mode_q == ModeHex3) begin
        mode_d = ModePlain;
        code_d = '0;
        res[0].has_byte = 1'b1;
        res[1].has_byte = 1'b1;
        res[2].has_byte = 1'b1;
        if (cp[15:7] == '0) begin
          n_res = 2'd1;
          res[0].out_byte = cp[7:0];
        end else if (cp[15:11] == '0) begin
          n_res = 2'd2;
          res[0].out_byte = Utf8Lead2 | {3'b000, cp[10:6]};
          res[1].out_byte = Utf8Cont | {2'b00, cp[5:0]};
        end else begin
          n_res = 2'd3;
          res[0].out_byte = Utf8Lead3 | {4'b0000, cp[15:12]};
          res[1].out_byte = Utf8Cont | {2'b00, cp[11:6]};
          res[2].out_byte = Utf8Cont | {2'b00, cp[5:0]};
        end
      end else begin
        code_d = cp;
        mode_d = mode_q + 3'd1;
      end
    end else begin
      // plain mode, also unused mode codes
      mode_d = ModePlain;
      if (s1_eoi_q || s1_byte_q == ChQuote) begin
        res[0].string_done = 1'b1;
        n_res  = 2'd1;
        code_d = '0;
      end else if (s1_byte_q == ChBackslash) begin
        mode_d = ModeEsc;
      end else begin
        res[0].out_byte = s1_byte_q;
        res[0].has_byte = 1'b1;
        n_res = 2'd1;
      end
    end

    // mark the final word of this input
    for (int k = 0; k < MaxRes; k++) res[k].last = (n_res == 2'(k + 1));
  end

  // Decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModePlain;
      code_q <= '0;
    end else if (s1_fire) begin
      mode_q <= mode_d;
      code_q <= code_d;
    end
  end

  // Result buffer storage
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      for (int k = 0; k < MaxRes; k++) begin
        if (2'(k) < n_res) buf_q[wr_ptr_q + BufPtrW'(k)] <= res[k];
      end
    end
  end

  // Result buffer pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (s1_fire) wr_ptr_q <= wr_ptr_q + BufPtrW'(n_res);
      if (out_fire) rd_ptr_q <= rd_ptr_q + BufPtrW'(1);
      cnt_q <= cnt_q + BufCntW'(s1_fire ? n_res : 2'd0) - BufCntW'(out_fire);
    end
  end

  // Head word drives the outputs
  assign out_byte_o     = buf_q[rd_ptr_q].out_byte;
  assign has_byte_o     = buf_q[rd_ptr_q].has_byte;
  assign string_done_o  = buf_q[rd_ptr_q].string_done;
  assign decode_error_o = buf_q[rd_ptr_q].decode_error;
  assign last_o         = buf_q[rd_ptr_q].last;

endmodule

`default_nettype wire

[rtl/core/jsu_checker.sv]
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks for the JSON string unescaper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       out_valid_o,
  input wire       out_ready_i,
  input wire [7:0] out_byte_o,
  input wire       has_byte_o,
  input wire       string_done_o,
  input wire       decode_error_o,
  input wire       last_o
);

  // No word shows while in reset
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output word valid during reset");

  // A stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(has_byte_o) && $stable(string_done_o) && $stable(last_o))
    else $error("stalled output word changed");

  // End of string carries no byte and closes the input's words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_done_o |-> last_o && !has_byte_o && out_byte_o == 8'h00)
    else $error("end-of-string word malformed");

  // Errors only on end of string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && decode_error_o |-> string_done_o)
    else $error("error without end of string");

  // A word without a byte must end the string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_byte_o |-> string_done_o)
    else $error("empty word that does not end the string");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);

`default_nettype wire

[sim/json_string_unescape_utf8_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_test
// Self-checking bench for the JSON string unescaper. A behavioral decoder runs
// on every accepted input word and queues the bytes and end marks it expects.
// Each output word is checked against the queue. Directed strings cover plain
// bytes, every escape, one- and three-byte UTF-8 widths and the error endings.
// Random strings then run under sender gaps and receiver stalls, and a long output hold-off stalls the input.
// ----------------------------------------------------------------------------

module json_string_unescape_utf8_test;
  import jsu_pkg::*;

  localparam int HoldCycles  = 80;
  localparam int DrainCycles = 20;

  logic       clk_i;
  logic       rst_ni       = 1'b1;
  logic       in_valid     = 1'b0;
  logic [7:0] in_byte      = 8'h00;
  logic       end_of_input = 1'b0;
  logic       out_ready    = 1'b0;
  wire        in_ready;
  wire        out_valid;
  wire  [7:0] out_byte;
  wire        has_byte;
  wire        string_done;
  wire        decode_error;
  wire        last_word;

  // Decoder state mirrored by the bench
  logic [2:0]  dec_mode = ModePlain;
  logic [15:0] dec_code = '0;
  res_t        decoded_words[$];

  int unsigned fail_count    = 0;
  int unsigned items_sent    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  logic        hold_req      = 1'b0;
  int          hold_left     = 0;
  res_t        want;

  json_string_unescape_utf8 dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .in_byte_i      (in_byte),
    .end_of_input_i (end_of_input),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .out_byte_o     (out_byte),
    .has_byte_o     (has_byte),
    .string_done_o  (string_done),
    .decode_error_o (decode_error),
    .last_o         (last_word)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Behavioral decoder
  // ---------------------------------------------------------------------------

  // Hex digit value, -1 for anything else
  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic res_t make_word(input logic [7:0] b, input logic has,
                                     input logic done, input logic err);
    res_t w;
    w.out_byte     = b;
    w.has_byte     = has;
    w.string_done  = done;
    w.decode_error = err;
    w.last         = 1'b0;
    return w;
  endfunction

  // Advance the decoder by one accepted word and queue what it yields
  task automatic decode_word(input logic [7:0] c, input logic eoi);
    res_t        words[3];
    int          n;
    int          h;
    logic [15:0] cp;
    n = 0;
    h = hex_nibble(c);
    if (dec_mode == ModeEsc) begin
      dec_mode = ModePlain;
      if (eoi) begin
        words[n++] = make_word(8'h00, 1'b0, 1'b1, 1'b1);
      end else begin
        case (c)
          ChQuote, ChBackslash, ChSlash: words[n++] = make_word(c, 1'b1, 1'b0, 1'b0);
          ChB: words[n++] = make_word(CodeBs, 1'b1, 1'b0, 1'b0);
          ChF: words[n++] = make_word(CodeFf, 1'b1, 1'b0, 1'b0);
          ChN: words[n++] = make_word(CodeLf, 1'b1, 1'b0, 1'b0);
          ChR: words[n++] = make_word(CodeCr, 1'b1, 1'b0, 1'b0);
          ChT: words[n++] = make_word(CodeHt, 1'b1, 1'b0, 1'b0);
          ChU: begin
            dec_mode = ModeHex0;
            dec_code = '0;
          end
          default: words[n++] = make_word(8'h00, 1'b0, 1'b1, 1'b1);
        endcase
      end
    end else if (dec_mode >= ModeHex0 && dec_mode <= ModeHex3) begin
      if (eoi || h < 0) begin
        words[n++] = make_word(8'h00, 1'b0, 1'b1, 1'b1);
        dec_mode = ModePlain;
        dec_code = '0;
      end else begin
        cp = {dec_code[11:0], 4'(h)};
        if (dec_mode == ModeHex3) begin
          // UTF-8 encode the finished code unit
          if (cp < 16'h0080) begin
            words[n++] = make_word(cp[7:0], 1'b1, 1'b0, 1'b0);
          end else if (cp < 16'h0800) begin
            words[n++] = make_word(Utf8Lead2 | {3'b0, cp[10:6]}, 1'b1, 1'b0, 1'b0);
            words[n++] = make_word(Utf8Cont | {2'b0, cp[5:0]}, 1'b1, 1'b0, 1'b0);
          end else begin
            words[n++] = make_word(Utf8Lead3 | {4'b0, cp[15:12]}, 1'b1, 1'b0, 1'b0);
            words[n++] = make_word(Utf8Cont | {2'b0, cp[11:6]}, 1'b1, 1'b0, 1'b0);
            words[n++] = make_word(Utf8Cont | {2'b0, cp[5:0]}, 1'b1, 1'b0, 1'b0);
          end
          dec_mode = ModePlain;
          dec_code = '0;
        end else begin
          dec_code = cp;
          dec_mode = dec_mode + 3'd1;
        end
      end
    end else begin
      // plain mode, unused codes included
      dec_mode = ModePlain;
      if (eoi || c == ChQuote) begin
        words[n++] = make_word(8'h00, 1'b0, 1'b1, 1'b0);
        dec_code = '0;
      end else if (c == ChBackslash) begin
        dec_mode = ModeEsc;
      end else begin
        words[n++] = make_word(c, 1'b1, 1'b0, 1'b0);
      end
    end
    if (n > 0) words[n - 1].last = 1'b1;
    for (int k = 0; k < n; k++) decoded_words.push_back(words[k]);
  endtask

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one word and hold it until accepted; valid stays up between words unless a random sender gap drops it
  task automatic send_word(input logic [7:0] b, input logic eoi);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    in_byte      <= b;
    end_of_input <= eoi;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    decode_word(b, eoi);
    items_sent++;
  endtask

  task automatic send_escape(input logic [7:0] letter);
    send_word(ChBackslash, 1'b0);
    send_word(letter, 1'b0);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return "0" + {4'b0, v};
    return ($urandom_range(0, 1) ? "a" : "A") + {4'b0, v} - 8'd10;
  endfunction

  // \u escape with four digits in mixed case
  task automatic send_unicode(input logic [15:0] cp);
    send_escape(ChU);
    for (int k = 3; k >= 0; k--) send_word(hex_char(cp[4*k +: 4]), 1'b0);
  endtask

  function automatic logic [7:0] short_escape(input int k);
    case (k)
      0: return ChQuote;
      1: return ChBackslash;
      2: return ChSlash;
      3: return ChB;
      4: return ChF;
      5: return ChN;
      6: return ChR;
      default: return ChT;
    endcase
  endfunction

  function automatic bit is_escape_letter(input logic [7:0] c);
    case (c)
      ChQuote, ChBackslash, ChSlash, ChB, ChF, ChN, ChR, ChT, ChU: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] random_plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == ChQuote || b == ChBackslash);
    return b;
  endfunction

  // Code units spread over the 1, 2 and 3 byte encodings and their edges
  function automatic logic [15:0] random_code_unit();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(16'h0000, 16'h007F));
      1: return 16'($urandom_range(16'h0080, 16'h07FF));
      2: return 16'($urandom_range(16'h0800, 16'hFFFF));
      default: begin
        case ($urandom_range(0, 5))
          0: return 16'h0000;
          1: return 16'h007F;
          2: return 16'h0080;
          3: return 16'h07FF;
          4: return 16'h0800;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  // One string: mostly well formed, some broken or raw noise
  task automatic send_random_string();
    int         count;
    logic [7:0] b;
    if ($urandom_range(0, 99) < 80) begin
      count = $urandom_range(1, 6);
      for (int k = 0; k < count; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: send_word(random_plain_byte(), 1'b0);
          5, 6: send_escape(short_escape($urandom_range(0, 7)));
          default: send_unicode(random_code_unit());
        endcase
      end
      if ($urandom_range(0, 4) == 0) send_word(8'($urandom_range(0, 255)), 1'b1);
      else send_word(ChQuote, 1'b0);
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          // unknown escape letter
          do b = 8'($urandom_range(0, 255)); while (is_escape_letter(b));
          send_escape(b);
        end
        1: begin
          // bad digit somewhere in a \u escape
          send_escape(ChU);
          count = $urandom_range(0, 3);
          for (int k = 0; k < count; k++) send_word(hex_char(4'($urandom_range(0, 15))), 1'b0);
          do b = 8'($urandom_range(0, 255)); while (hex_nibble(b) >= 0);
          send_word(b, 1'b0);
        end
        2: begin
          // input ends inside an escape
          send_word(ChBackslash, 1'b0);
          if ($urandom_range(0, 1)) begin
            send_word(ChU, 1'b0);
            count = $urandom_range(0, 3);
            for (int k = 0; k < count; k++) send_word(hex_char(4'($urandom_range(0, 15))), 1'b0);
          end
          send_word(8'($urandom_range(0, 255)), 1'b1);
        end
        default: begin
          // raw bytes, quotes and backslashes frequent
          count = $urandom_range(1, 4);
          for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 3))
              0: send_word(ChQuote, 1'b0);
              1: send_word(ChBackslash, 1'b0);
              default: send_word(8'($urandom_range(0, 255)), 1'b0);
            endcase
          end
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Receiver ready: random stalls, or a counted hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_req  <= 1'b0;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic check_field(input string name, input int expected, input int actual);
    if (expected != actual) begin
      $error("%s mismatch: expected %0h, got %0h", name, expected, actual);
      fail_count++;
    end
  endtask

  // Compare each accepted word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (decoded_words.size() == 0) begin
        $error("unexpected word: byte %0h has %0b done %0b err %0b last %0b",
               out_byte, has_byte, string_done, decode_error, last_word);
        fail_count++;
      end else begin
        want = decoded_words.pop_front();
        check_field("out_byte", want.out_byte, out_byte);
        check_field("has_byte", want.has_byte, has_byte);
        check_field("string_done", want.string_done, string_done);
        check_field("decode_error", want.decode_error, decode_error);
        check_field("last", want.last, last_word);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Byte extremes pass through, end of input closes the string cleanly
  task automatic test_plain_bytes();
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h5A, 1'b1);
  endtask

  task automatic test_short_escapes();
    for (int k = 0; k < 8; k++) send_escape(short_escape(k));
    send_word(ChQuote, 1'b0);
  endtask

  // Zero unit gives one zero byte; the top unit gives three, digits in both cases
  task automatic test_unicode_units();
    send_unicode(16'h0000);
    send_escape(ChU);
    send_word("F", 1'b0);
    send_word("f", 1'b0);
    send_word("F", 1'b0);
    send_word("f", 1'b0);
  endtask

  // Unknown escape, non-hex digit, end inside escape and inside \u
  task automatic test_bad_escapes();
    send_escape("x");
    send_escape(ChU);
    send_word("0", 1'b0);
    send_word("g", 1'b0);
    send_word(ChBackslash, 1'b0);
    send_word(8'hFF, 1'b1);
    send_escape(ChU);
    send_word("1", 1'b0);
    send_word(8'h00, 1'b1);
  endtask

  // Receiver holds off while plain bytes keep coming, so the input stalls
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req     <= 1'b1;
    for (int k = 0; k < 30; k++) send_word(random_plain_byte(), 1'b0);
    send_word(ChQuote, 1'b0);
  endtask

  task automatic test_random_strings(input int unsigned n, input int unsigned idle,
                                     input int unsigned stall);
    int unsigned stop_at;
    send_idle_pct = idle;
    stall_pct     = stall;
    stop_at       = items_sent + n;
    while (items_sent < stop_at) send_random_string();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_plain_bytes();
    test_short_escapes();
    test_unicode_units();
    test_bad_escapes();
    test_random_strings(50, 0, 0);
    test_random_strings(50, 49, 0);
    test_random_strings(50, 0, 49);
    test_output_backpressure();
    test_random_strings(50, 37, 37);

    in_valid <= 1'b0;
    while (decoded_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
